// ===== rtl/gplb_pkg.sv =====
// shared types, constants and helpers of the glyph pen layout blitter
package gplb_pkg;

   localparam int MAX_SPAN   = 1024;
   localparam int MAP_WORDS  = 32768;
   localparam int MAX_GLYPH  = 32;
   localparam int MAP_AW     = $clog2(MAP_WORDS);
   localparam int WORD_W     = 17;
   localparam int Q_DEPTH    = 4;
   localparam int Q_AW       = $clog2(Q_DEPTH);

   // register indexes of the csr port
   localparam logic [2:0] CSR_SPAN_X   = 3'd0;
   localparam logic [2:0] CSR_SPAN_Y   = 3'd1;
   localparam logic [2:0] CSR_LINE_ADV = 3'd2;
   localparam logic [2:0] CSR_LINE_GAP = 3'd3;
   localparam logic [2:0] CSR_CHAR_GAP = 3'd4;
   localparam logic [2:0] CSR_VERTICAL = 3'd5;

   // request function codes
   localparam logic [2:0] FUNC_HEADER  = 3'd0;
   localparam logic [2:0] FUNC_COLUMN  = 3'd1;
   localparam logic [2:0] FUNC_NEWLINE = 3'd2;
   localparam logic [2:0] FUNC_CLEAR   = 3'd3;
   localparam logic [2:0] FUNC_READ    = 3'd4;

   // pen row after reset: 240 - 16
   localparam logic signed [11:0] HOME_ROW_RESET = 12'sd224;

   typedef enum logic [1:0] {
      OP_NOP,
      OP_PLOT,
      OP_CLEAR,
      OP_READ
   } op_type;

   typedef struct packed {
      logic [10:0] span_x;
      logic [10:0] span_y;
      logic [7:0]  line_advance;
      logic [7:0]  line_gap;
      logic [7:0]  char_gap;
      logic        vertical_mode;
   } cfg_type;

   // one queued command from front to back
   typedef struct packed {
      op_type             op;
      logic               status;
      logic signed [12:0] x;
      logic signed [11:0] y0;
      logic [5:0]         rows;
      logic [31:0]        bits;
      logic [14:0]        addr;
   } cmd_type;

   typedef enum logic [2:0] {
      S_INIT,
      S_IDLE,
      S_ROW,
      S_ADDR,
      S_WRITE,
      S_CLEAR,
      S_READ
   } state_type;

   // saturate to the signed 12-bit pen range
   function automatic logic signed [11:0] sat12(input logic signed [13:0] v);
      logic signed [11:0] r;
      if (v > 14'sd2047) r = 12'sd2047;
      else if (v < -14'sd2048) r = -12'sd2048;
      else r = v[11:0];
      return r;
   endfunction

   // span limited to the largest supported extent
   function automatic logic [10:0] eff_span(input logic [10:0] s);
      logic [10:0] r;
      if (s > 11'(MAX_SPAN)) r = 11'(MAX_SPAN);
      else r = s;
      return r;
   endfunction

endpackage

// ===== rtl/gplb_front.sv =====
// front part: pen layout of headers, column bookkeeping, command issue
module gplb_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  gplb_pkg::cfg_type cfg,
   input  logic [2:0]       req_func,
   input  logic [5:0]       req_glyph_width,
   input  logic [5:0]       req_glyph_height,
   input  logic signed [6:0] req_bearing_x,
   input  logic signed [6:0] req_bearing_y,
   input  logic [6:0]       req_advance,
   input  logic [31:0]      req_column_bits,
   input  logic [14:0]      req_word_address,
   output gplb_pkg::cmd_type cmd
);
   import gplb_pkg::*;

   logic signed [11:0] pen_col_ff, pen_col_in;
   logic signed [11:0] pen_row_ff, pen_row_in;
   logic signed [11:0] org_col_ff, org_col_in;
   logic signed [11:0] org_row_ff, org_row_in;
   logic [5:0]         col_idx_ff, col_idx_in;
   logic [5:0]         rows_ff, rows_in;
   logic [5:0]         cols_ff, cols_in;
   logic               live_ff, live_in;

   logic signed [13:0] px0, py0, bx, by, px1, px2, py2, sx14, la14, lg14, cg14;
   logic signed [11:0] home_row, py_next;
   logic               wrap, drop;

   // header layout arithmetic
   always_comb begin
      px0  = 14'(pen_col_ff);
      py0  = 14'(pen_row_ff);
      bx   = 14'(req_bearing_x);
      by   = 14'(req_bearing_y);
      sx14 = $signed({3'b000, eff_span(cfg.span_x)});
      la14 = $signed({6'b000000, cfg.line_advance});
      lg14 = $signed({6'b000000, cfg.line_gap});
      cg14 = $signed({6'b000000, cfg.char_gap});
      home_row = sat12($signed({3'b000, eff_span(cfg.span_y)}) - la14);
      py_next  = sat12(py0 - la14 - lg14);
      if (pen_col_ff == 12'sd0 && req_bearing_x < 7'sd0) px1 = -bx;
      else px1 = px0;
      wrap = (px1 + $signed({8'b0, req_glyph_width}) + bx) > sx14;
      px2  = wrap ? 14'sd0 : px1;
      py2  = wrap ? 14'(py_next) : py0;
      drop = (py2 + by) < 14'sd0;
   end

   // next state and command
   always_comb begin
      pen_col_in = pen_col_ff;
      pen_row_in = pen_row_ff;
      org_col_in = org_col_ff;
      org_row_in = org_row_ff;
      col_idx_in = col_idx_ff;
      rows_in    = rows_ff;
      cols_in    = cols_ff;
      live_in    = live_ff;
      cmd.op     = OP_NOP;
      cmd.status = 1'b0;
      cmd.x      = $signed({org_col_ff[11], org_col_ff}) + $signed({7'b0, col_idx_ff});
      cmd.y0     = org_row_ff;
      cmd.rows   = rows_ff;
      cmd.bits   = req_column_bits;
      cmd.addr   = req_word_address;
      if (accept) begin
         unique case (req_func)
            FUNC_HEADER: begin
               if (drop) begin
                  pen_col_in = 12'sd0;
                  pen_row_in = home_row;
                  live_in    = 1'b0;
                  cmd.status = 1'b1;
               end else begin
                  org_col_in = sat12(px2 + bx);
                  org_row_in = sat12(py2 + by);
                  col_idx_in = 6'd0;
                  cols_in    = (req_glyph_width > 6'(MAX_GLYPH)) ? 6'(MAX_GLYPH)
                                                                 : req_glyph_width;
                  rows_in    = (req_glyph_height > 6'd32) ? 6'd32 : req_glyph_height;
                  live_in    = (req_glyph_width != 6'd0);
                  pen_col_in = sat12(px2 + $signed({7'b0, req_advance}) + cg14);
                  pen_row_in = py2[11:0];
               end
            end
            FUNC_COLUMN: begin
               if (live_ff) begin
                  cmd.op     = OP_PLOT;
                  col_idx_in = col_idx_ff + 6'd1;
                  if (col_idx_in >= cols_ff) live_in = 1'b0;
               end
            end
            FUNC_NEWLINE: begin
               pen_col_in = 12'sd0;
               pen_row_in = py_next;
            end
            FUNC_CLEAR: begin
               pen_col_in = 12'sd0;
               pen_row_in = home_row;
               live_in    = 1'b0;
               cmd.op     = OP_CLEAR;
            end
            FUNC_READ: cmd.op = OP_READ;
            default: ;
         endcase
      end
   end

   // pen and glyph registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pen_col_ff <= 12'sd0;
         pen_row_ff <= HOME_ROW_RESET;
         org_col_ff <= 12'sd0;
         org_row_ff <= 12'sd0;
         col_idx_ff <= 6'd0;
         rows_ff    <= 6'd0;
         cols_ff    <= 6'd0;
         live_ff    <= 1'b0;
      end else begin
         pen_col_ff <= pen_col_in;
         pen_row_ff <= pen_row_in;
         org_col_ff <= org_col_in;
         org_row_ff <= org_row_in;
         col_idx_ff <= col_idx_in;
         rows_ff    <= rows_in;
         cols_ff    <= cols_in;
         live_ff    <= live_in;
      end
   end

endmodule

// ===== rtl/gplb_queue.sv =====
// short command queue between front and back
module gplb_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  gplb_pkg::cmd_type push_cmd,
   input  logic              pop,
   output gplb_pkg::cmd_type head_cmd,
   output logic              empty,
   output logic              full
);
   import gplb_pkg::*;

   cmd_type             slot_ff [Q_DEPTH];
   logic [Q_AW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [Q_AW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [Q_AW:0]       count_ff, count_in;

   // pointers and fill level
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (Q_AW+1)'(push) - (Q_AW+1)'(pop);
      empty     = (count_ff == '0);
      full      = (count_ff == (Q_AW+1)'(Q_DEPTH));
      head_cmd  = slot_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // slot storage
   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= push_cmd;
   end

endmodule

// ===== rtl/gplb_back.sv =====
// back part: bitmap store, pixel read-modify-write, clear sweep and readout
module gplb_back (
   input  logic              clock,
   input  logic              reset,
   input  gplb_pkg::cfg_type cfg,
   input  gplb_pkg::cmd_type head_cmd,
   input  logic              empty,
   output logic              pop,
   output logic              init_busy,
   output logic              rsp_valid,
   output logic              rsp_status,
   output logic [31:0]       rsp_read_word
);
   import gplb_pkg::*;

   logic [31:0]        mem [MAP_WORDS];
   logic [31:0]        rd_data_ff;
   logic [MAP_AW-1:0]  mem_ra, mem_wa;
   logic [31:0]        mem_wd;
   logic               mem_we;

   state_type          state_ff, state_in;
   cmd_type            cmd_ff, cmd_in;
   logic [5:0]         row_ff, row_in;
   logic [10:0]        mul_a_ff, mul_a_in, mul_b_ff, mul_b_in, add_c_ff, add_c_in;
   logic [MAP_AW-1:0]  waddr_ff, waddr_in;
   logic [4:0]         bit_ff, bit_in;
   logic [MAP_AW-1:0]  clr_ff, clr_in;
   logic               rd_ok_ff, rd_ok_in;
   logic               fire;
   logic               fire_status;
   logic [31:0]        fire_word;

   logic [10:0]        sx, sy;
   logic signed [12:0] y;
   logic               in_bounds;
   logic [21:0]        pos;
   logic [WORD_W-1:0]  word;

   // pixel geometry
   always_comb begin
      sx  = eff_span(cfg.span_x);
      sy  = eff_span(cfg.span_y);
      y   = $signed({cmd_ff.y0[11], cmd_ff.y0}) + $signed({7'b0, row_ff});
      in_bounds = (cmd_ff.x >= 13'sd0) && (cmd_ff.x < $signed({2'b00, sx}))
               && (y >= 13'sd0) && (y < $signed({2'b00, sy}));
      pos  = 22'(mul_a_ff) * 22'(mul_b_ff) + 22'(add_c_ff);
      word = pos[21:5];
   end

   // sequencer
   always_comb begin
      state_in    = state_ff;
      cmd_in      = cmd_ff;
      row_in      = row_ff;
      mul_a_in    = mul_a_ff;
      mul_b_in    = mul_b_ff;
      add_c_in    = add_c_ff;
      waddr_in    = waddr_ff;
      bit_in      = bit_ff;
      clr_in      = clr_ff;
      rd_ok_in    = rd_ok_ff;
      pop         = 1'b0;
      fire        = 1'b0;
      fire_status = 1'b0;
      fire_word   = 32'd0;
      mem_ra      = waddr_ff;
      mem_wa      = clr_ff;
      mem_wd      = 32'd0;
      mem_we      = 1'b0;
      unique case (state_ff)
         S_INIT, S_CLEAR: begin
            mem_we = 1'b1;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == MAP_AW'(MAP_WORDS - 1)) begin
               state_in = S_IDLE;
               fire     = (state_ff == S_CLEAR);
            end
         end
         S_IDLE: begin
            if (!empty) begin
               pop    = 1'b1;
               cmd_in = head_cmd;
               row_in = 6'd0;
               clr_in = '0;
               unique case (head_cmd.op)
                  OP_NOP: begin
                     fire        = 1'b1;
                     fire_status = head_cmd.status;
                  end
                  OP_PLOT:  state_in = S_ROW;
                  OP_CLEAR: state_in = S_CLEAR;
                  OP_READ: begin
                     mem_ra   = head_cmd.addr[MAP_AW-1:0];
                     rd_ok_in = ({2'b00, head_cmd.addr} < WORD_W'(MAP_WORDS));
                     state_in = S_READ;
                  end
                  default: ;
               endcase
            end
         end
         S_ROW: begin
            if (row_ff == cmd_ff.rows) begin
               fire     = 1'b1;
               state_in = S_IDLE;
            end else if (cmd_ff.bits[row_ff[4:0]] && in_bounds) begin
               if (cfg.vertical_mode) begin
                  mul_a_in = 11'(sx - 11'(cmd_ff.x) - 11'd1);
                  mul_b_in = sy;
                  add_c_in = y[10:0];
               end else begin
                  mul_a_in = y[10:0];
                  mul_b_in = sx;
                  add_c_in = cmd_ff.x[10:0];
               end
               state_in = S_ADDR;
            end else begin
               row_in = row_ff + 6'd1;
            end
         end
         S_ADDR: begin
            if (word < WORD_W'(MAP_WORDS)) begin
               mem_ra   = word[MAP_AW-1:0];
               waddr_in = word[MAP_AW-1:0];
               bit_in   = pos[4:0];
               state_in = S_WRITE;
            end else begin
               row_in   = row_ff + 6'd1;
               state_in = S_ROW;
            end
         end
         S_WRITE: begin
            mem_we   = 1'b1;
            mem_wa   = waddr_ff;
            mem_wd   = rd_data_ff | (32'd1 << bit_ff);
            row_in   = row_ff + 6'd1;
            state_in = S_ROW;
         end
         S_READ: begin
            fire      = 1'b1;
            fire_word = rd_ok_ff ? rd_data_ff : 32'd0;
            state_in  = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
      init_busy = (state_ff == S_INIT);
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_INIT;
         clr_ff    <= '0;
         rsp_valid <= 1'b0;
      end else begin
         state_ff  <= state_in;
         clr_ff    <= clr_in;
         rsp_valid <= fire;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      row_ff        <= row_in;
      mul_a_ff      <= mul_a_in;
      mul_b_ff      <= mul_b_in;
      add_c_ff      <= add_c_in;
      waddr_ff      <= waddr_in;
      bit_ff        <= bit_in;
      rd_ok_ff      <= rd_ok_in;
      rsp_status    <= fire_status;
      rsp_read_word <= fire_word;
   end

   // bitmap store
   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_wa] <= mem_wd;
      rd_data_ff <= mem[mem_ra];
   end

endmodule

// ===== rtl/glyph_pen_layout_blitter_core.sv =====
// top level of the glyph pen layout blitter: csr registers and part wiring
//
// Usage: a request word is taken on a rising edge with start high and busy low.
// The front lays out headers and tracks the pen in that same edge, then queues
// a command (four slots) for the back, which owns the 32768 x 32 bitmap store.
// Every request yields one response word: rsp_valid is high for exactly one
// cycle with rsp_status and rsp_read_word. The receiver cannot stall.
// A column does one read-modify-write of a store word for each lit pixel
// that lies on the page; clear page sweeps the store at one word a cycle.
// busy is high while the queue is full.
// Reset: synchronous; the store is then swept to zero, with busy high,
// before the first request is taken. Csr writes (csr_we, index,
// data) are taken at any edge and are meant for an idle block.
module glyph_pen_layout_blitter_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [2:0]        req_func,
   input  logic [5:0]        req_glyph_width,
   input  logic [5:0]        req_glyph_height,
   input  logic signed [6:0] req_bearing_x,
   input  logic signed [6:0] req_bearing_y,
   input  logic [6:0]        req_advance,
   input  logic [31:0]       req_column_bits,
   input  logic [14:0]       req_word_address,
   output logic              rsp_valid,
   output logic              rsp_status,
   output logic [31:0]       rsp_read_word,
   input  logic              csr_we,
   input  logic [2:0]        csr_index,
   input  logic [10:0]       csr_wdata
);
   import gplb_pkg::*;

   cfg_type cfg_ff, cfg_in;
   cmd_type push_cmd, head_cmd;
   logic    accept, pop, empty, full, init_busy;

   assign busy   = full | init_busy;
   assign accept = start & ~busy;

   // csr register decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_SPAN_X:   cfg_in.span_x        = csr_wdata;
            CSR_SPAN_Y:   cfg_in.span_y        = csr_wdata;
            CSR_LINE_ADV: cfg_in.line_advance  = csr_wdata[7:0];
            CSR_LINE_GAP: cfg_in.line_gap      = csr_wdata[7:0];
            CSR_CHAR_GAP: cfg_in.char_gap      = csr_wdata[7:0];
            CSR_VERTICAL: cfg_in.vertical_mode = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.span_x        <= 11'd320;
         cfg_ff.span_y        <= 11'd240;
         cfg_ff.line_advance  <= 8'd16;
         cfg_ff.line_gap      <= 8'd0;
         cfg_ff.char_gap      <= 8'd0;
         cfg_ff.vertical_mode <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   gplb_front u_front (
      .clock            (clock),
      .reset            (reset),
      .accept           (accept),
      .cfg              (cfg_ff),
      .req_func         (req_func),
      .req_glyph_width  (req_glyph_width),
      .req_glyph_height (req_glyph_height),
      .req_bearing_x    (req_bearing_x),
      .req_bearing_y    (req_bearing_y),
      .req_advance      (req_advance),
      .req_column_bits  (req_column_bits),
      .req_word_address (req_word_address),
      .cmd              (push_cmd)
   );

   gplb_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (accept),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head_cmd (head_cmd),
      .empty    (empty),
      .full     (full)
   );

   gplb_back u_back (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .head_cmd      (head_cmd),
      .empty         (empty),
      .pop           (pop),
      .init_busy     (init_busy),
      .rsp_valid     (rsp_valid),
      .rsp_status    (rsp_status),
      .rsp_read_word (rsp_read_word)
   );

endmodule
